// File: src/lpd_pkg.sv
// package with shared constants, types and helpers of the lidar packet deframer
`default_nettype none
package lpd_pkg;

    localparam int POINTS_PER_PACKET = 12;
    localparam int POINT_DIV         = POINTS_PER_PACKET - 1;
    localparam int PAYLOAD_LEN       = 44;
    localparam int ADDR_W            = $clog2(PAYLOAD_LEN);
    localparam int FULL_TURN         = 36000;
    localparam int FIRST_POINT_OFF   = 4;
    localparam int POINT_STRIDE      = 3;
    localparam int TAIL_OFF          = 40;
    localparam int CRC_STEPS         = 4;
    localparam int HDR_BYTES         = 8;
    localparam int PADDR_W           = 4;

    // reciprocal of POINT_DIV, exact floor division of any 16-bit value
    localparam int          DIV_SHIFT = 16 + $clog2(POINT_DIV);
    localparam logic [16:0] DIV_RECIP = 17'(((1 << DIV_SHIFT) + POINT_DIV - 1) / POINT_DIV);

    localparam logic [7:0] POLY_RESET   = 8'h4D;
    localparam logic [7:0] SEED_RESET   = 8'hD8;
    localparam logic [7:0] HEADER_RESET = 8'h54;
    localparam logic [7:0] VERLEN_RESET = 8'h2C;

    typedef enum logic [1:0] {
        REG_POLY,
        REG_SEED,
        REG_HEADER,
        REG_VERLEN
    } lpd_reg_t;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_SYNC,
        ST_DATA,
        ST_CRC,
        ST_RDHDR,
        ST_DIV,
        ST_RDPT,
        ST_MOD,
        ST_EMIT
    } lpd_state_t;

    // one msb-first crc8 bit step
    function automatic logic [7:0] crc_shift(input logic [7:0] r, input logic [7:0] poly);
        logic [7:0] s;
        s = {r[6:0], 1'b0};
        return r[7] ? (s ^ poly) : s;
    endfunction

    // payload address of header slot k: speed, start angle, end angle, timestamp
    function automatic logic [ADDR_W-1:0] hdr_addr(input logic [2:0] k);
        logic [ADDR_W-1:0] base;
        base = k[2] ? ADDR_W'(TAIL_OFF - 4) : '0;
        return base + ADDR_W'(k);
    endfunction

endpackage
`default_nettype wire

// File: src/lpd_byte_if.sv
// byte channel carrying received serial bytes
`default_nettype none
interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: src/lpd_point_if.sv
// point channel carrying one decoded measurement point
`default_nettype none
interface lpd_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_mm;
    logic [7:0]  intensity;
    logic [15:0] angle_centideg;
    logic [3:0]  point_index;
    logic [15:0] rotor_speed;
    logic [15:0] time_stamp;
    logic        last_point;

    modport source (
        output valid, output distance_mm, output intensity, output angle_centideg,
        output point_index, output rotor_speed, output time_stamp, output last_point,
        input ready
    );
    modport sink (
        input valid, input distance_mm, input intensity, input angle_centideg,
        input point_index, input rotor_speed, input time_stamp, input last_point,
        output ready
    );
endinterface
`default_nettype wire

// File: src/lidar_packet_deframer.sv
// top level of the lidar packet deframer: sync hunt, crc8 check and point decode
//
// byte_in takes one received byte per transfer. The block hunts for the header
// byte and the version/length byte, then stores 44 payload bytes in a small
// memory and checks the trailing crc8 byte. A good packet gives 12 transfers on
// point_out, point_index 0 to 11, last_point set on the final one; a bad packet
// gives none. Configuration registers sit on the apb port at 0x0, 0x4, 0x8, 0xc.
// Each payload byte is taken and then run through 4 passes of a two-bit crc
// step unit, with byte_in not ready during the passes. After a good check
// byte the header fields are read from the memory and the angle step is formed
// by a reciprocal multiply; each point is then read from the memory, reduced
// modulo 36000 by a compare-subtract unit, and waits in the output register
// until taken. While point_out is stalled nothing moves and byte_in stays not
// ready. Reset returns to hunting with default registers.
`default_nettype none
module lidar_packet_deframer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lpd_byte_if.sink                             byte_in,
    lpd_point_if.source                          point_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lpd_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import lpd_pkg::*;

    logic [7:0]        poly_reg, seed_reg, header_reg, verlen_reg;
    lpd_state_t        state_reg, state_next;
    logic [3:0]        seq_reg, seq_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        crc_reg, crc_next;
    logic [16:0]       acc_reg, acc_next;
    logic [3:0]        pt_reg, pt_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [15:0]       quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [15:0]       step_reg, step_next;
    logic [7:0]        hdr_reg [HDR_BYTES];
    logic [7:0]        hdr_next [HDR_BYTES];
    logic [7:0]        pb_reg [POINT_STRIDE];
    logic [7:0]        pb_next [POINT_STRIDE];
    logic [15:0]       dist_reg, dist_next;
    logic [7:0]        inten_reg, inten_next;
    logic [15:0]       angle_reg, angle_next;
    logic              last_reg, last_next;

    logic [7:0]        mem [PAYLOAD_LEN];
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic              mem_we;

    logic              cfg_we;
    logic              in_xfer;
    logic              out_xfer;

    assign pready   = 1'b1;
    assign cfg_we   = psel & penable & pwrite;
    assign in_xfer  = byte_in.valid & byte_in.ready;
    assign out_xfer = point_out.valid & point_out.ready;

    assign byte_in.ready = (state_reg == ST_HUNT) || (state_reg == ST_SYNC)
                           || (state_reg == ST_DATA);
    assign mem_we = in_xfer && (state_reg == ST_DATA) && (cnt_reg != ADDR_W'(PAYLOAD_LEN));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            seed_reg   <= SEED_RESET;
            header_reg <= HEADER_RESET;
            verlen_reg <= VERLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (lpd_reg_t'(paddr[3:2]))
                REG_POLY:   poly_reg   <= pwdata[7:0];
                REG_SEED:   seed_reg   <= pwdata[7:0];
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_VERLEN: verlen_reg <= pwdata[7:0];
                default:    poly_reg   <= poly_reg;
            endcase
        end
    end

    always_comb
    begin
        case (lpd_reg_t'(paddr[3:2]))
            REG_POLY:   prdata = 32'(poly_reg);
            REG_SEED:   prdata = 32'(seed_reg);
            REG_HEADER: prdata = 32'(header_reg);
            REG_VERLEN: prdata = 32'(verlen_reg);
            default:    prdata = '0;
        endcase
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg] <= byte_in.rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            seq_reg   <= '0;
            cnt_reg   <= '0;
            crc_reg   <= '0;
            acc_reg   <= '0;
            pt_reg    <= '0;
            ptr_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
            step_reg  <= '0;
            hdr_reg   <= '{default: '0};
            pb_reg    <= '{default: '0};
            dist_reg  <= '0;
            inten_reg <= '0;
            angle_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            acc_reg   <= acc_next;
            pt_reg    <= pt_next;
            ptr_reg   <= ptr_next;
            quo_reg   <= quo_next;
            neg_reg   <= neg_next;
            step_reg  <= step_next;
            hdr_reg   <= hdr_next;
            pb_reg    <= pb_next;
            dist_reg  <= dist_next;
            inten_reg <= inten_next;
            angle_reg <= angle_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        logic [32:0]        recip_prod;
        logic [15:0]        q_div;
        logic [15:0]        start_ang;
        logic [15:0]        end_ang;
        logic signed [17:0] span;

        state_next = state_reg;
        seq_next   = seq_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        acc_next   = acc_reg;
        pt_next    = pt_reg;
        ptr_next   = ptr_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        hdr_next   = hdr_reg;
        pb_next    = pb_reg;
        dist_next  = dist_reg;
        inten_next = inten_reg;
        angle_next = angle_reg;
        last_next  = last_reg;
        rd_addr    = '0;

        // floor(|span| / POINT_DIV)
        recip_prod = 33'(quo_reg) * 33'(DIV_RECIP);
        q_div      = 16'(recip_prod >> DIV_SHIFT);
        start_ang  = {hdr_reg[3], hdr_reg[2]};
        end_ang    = {hdr_reg[5], hdr_reg[4]};
        if (start_ang <= end_ang)
        begin
            span = $signed({2'b00, end_ang}) - $signed({2'b00, start_ang});
        end
        else
        begin
            span = 18'(FULL_TURN) + $signed({2'b00, end_ang}) - $signed({2'b00, start_ang});
        end

        case (state_reg)
            ST_HUNT:
            begin
                if (in_xfer && byte_in.rx_byte == header_reg)
                begin
                    state_next = ST_SYNC;
                end
            end
            ST_SYNC:
            begin
                if (in_xfer)
                begin
                    if (byte_in.rx_byte == verlen_reg)
                    begin
                        state_next = ST_DATA;
                        cnt_next   = '0;
                        crc_next   = seed_reg;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg != ADDR_W'(PAYLOAD_LEN))
                    begin
                        crc_next   = crc_reg ^ byte_in.rx_byte;
                        cnt_next   = cnt_reg + 1'b1;
                        seq_next   = '0;
                        state_next = ST_CRC;
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (byte_in.rx_byte == crc_reg)
                        begin
                            seq_next   = '0;
                            pt_next    = '0;
                            ptr_next   = ADDR_W'(FIRST_POINT_OFF);
                            state_next = ST_RDHDR;
                        end
                        else
                        begin
                            state_next = ST_HUNT;
                        end
                    end
                end
            end
            ST_CRC:
            begin
                crc_next = crc_shift(crc_shift(crc_reg, poly_reg), poly_reg);
                seq_next = seq_reg + 1'b1;
                if (seq_reg == 4'(CRC_STEPS - 1))
                begin
                    state_next = ST_DATA;
                end
            end
            ST_RDHDR:
            begin
                if (seq_reg < 4'(HDR_BYTES))
                begin
                    rd_addr = hdr_addr(seq_reg[2:0]);
                end
                if (seq_reg != '0)
                begin
                    hdr_next[3'(seq_reg - 4'd1)] = rd_data_reg;
                end
                seq_next = seq_reg + 1'b1;
                if (seq_reg == 4'(HDR_BYTES))
                begin
                    neg_next   = span[17];
                    quo_next   = span[17] ? 16'(-span) : span[15:0];
                    seq_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                step_next  = neg_reg ? (16'd0 - q_div) : q_div;
                acc_next   = {1'b0, start_ang};
                seq_next   = '0;
                state_next = ST_RDPT;
            end
            ST_RDPT:
            begin
                if (seq_reg < 4'(POINT_STRIDE))
                begin
                    rd_addr = ptr_reg + ADDR_W'(seq_reg);
                end
                if (seq_reg != '0)
                begin
                    pb_next[2'(seq_reg - 4'd1)] = rd_data_reg;
                end
                seq_next = seq_reg + 1'b1;
                if (seq_reg == 4'(POINT_STRIDE))
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (acc_reg >= 17'(FULL_TURN))
                begin
                    acc_next = acc_reg - 17'(FULL_TURN);
                end
                else
                begin
                    dist_next  = {pb_reg[1], pb_reg[0]};
                    inten_next = pb_reg[2];
                    angle_next = acc_reg[15:0];
                    last_next  = (pt_reg == 4'(POINTS_PER_PACKET - 1));
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        pt_next    = pt_reg + 1'b1;
                        ptr_next   = ptr_reg + ADDR_W'(POINT_STRIDE);
                        acc_next   = acc_reg + {1'b0, step_reg};
                        seq_next   = '0;
                        state_next = ST_RDPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    assign point_out.valid          = (state_reg == ST_EMIT);
    assign point_out.distance_mm    = dist_reg;
    assign point_out.intensity      = inten_reg;
    assign point_out.angle_centideg = angle_reg;
    assign point_out.point_index    = pt_reg;
    assign point_out.rotor_speed    = {hdr_reg[1], hdr_reg[0]};
    assign point_out.time_stamp     = {hdr_reg[7], hdr_reg[6]};
    assign point_out.last_point     = last_reg;

endmodule
`default_nettype wire

// File: dv/lidar_packet_deframer_tb.sv
// testbench of the lidar packet deframer: byte stimulus, point prediction and checking
module lidar_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 80;
    localparam int PHASE_BYTES   = 10;

    typedef enum logic [1:0] {
        HUNT_HEADER,
        HUNT_VERLEN,
        TAKE_PAYLOAD
    } frame_state_t;

    typedef struct {
        logic [15:0] distance_mm;
        logic [7:0]  intensity;
        logic [15:0] angle_centideg;
        logic [3:0]  point_index;
        logic [15:0] rotor_speed;
        logic [15:0] time_stamp;
        logic        last_point;
    } scan_point_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    lpd_byte_if  byte_bus ();
    lpd_point_if point_bus ();

    // register copies, written only while the block is idle
    logic [7:0] cfg_poly   = POLY_RESET;
    logic [7:0] cfg_seed   = SEED_RESET;
    logic [7:0] cfg_header = HEADER_RESET;
    logic [7:0] cfg_verlen = VERLEN_RESET;

    frame_state_t frame_state;
    int           payload_fill;
    logic [7:0]   frame_crc;
    logic [7:0]   frame_body [PAYLOAD_LEN];

    logic [7:0]  rx_pending [$];
    scan_point_t expected_points [$];
    int          bytes_queued = 0;
    bit          failed = 1'b0;
    int          cycle_count = 0;

    int  send_gap = 0;
    bit  send_burst = 1'b0;
    int  hold_left = 0;
    bit  recv_burst = 1'b0;
    int  points_taken = 0;

    lidar_packet_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_bus),
        .point_out (point_bus),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        int          start_ang;
        int          end_ang;
        int          span;
        int          off;
        logic [15:0] step;
        scan_point_t pt;
        case (frame_state)
            HUNT_HEADER:
            begin
                if (b == cfg_header)
                    frame_state = HUNT_VERLEN;
            end
            HUNT_VERLEN:
            begin
                if (b == cfg_verlen)
                begin
                    frame_state  = TAKE_PAYLOAD;
                    payload_fill = 0;
                    frame_crc    = cfg_seed;
                end
                else
                    frame_state = HUNT_HEADER;
            end
            default:
            begin
                if (payload_fill < PAYLOAD_LEN)
                begin
                    frame_body[payload_fill] = b;
                    frame_crc = crc8_fold(frame_crc, b, cfg_poly);
                    payload_fill++;
                end
                else
                begin
                    frame_state  = HUNT_HEADER;
                    payload_fill = 0;
                    if (b == frame_crc)
                    begin
                        start_ang = int'({frame_body[3], frame_body[2]});
                        end_ang   = int'({frame_body[TAIL_OFF + 1], frame_body[TAIL_OFF]});
                        span = (start_ang <= end_ang) ? end_ang - start_ang
                                                      : FULL_TURN + end_ang - start_ang;
                        step = 16'(span / POINT_DIV);
                        for (int k = 0; k < POINTS_PER_PACKET; k++)
                        begin
                            off = FIRST_POINT_OFF + POINT_STRIDE * k;
                            pt.distance_mm    = {frame_body[off + 1], frame_body[off]};
                            pt.intensity      = frame_body[off + 2];
                            pt.angle_centideg = 16'((start_ang + int'(step) * k) % FULL_TURN);
                            pt.point_index    = 4'(k);
                            pt.rotor_speed    = {frame_body[1], frame_body[0]};
                            pt.time_stamp     = {frame_body[43], frame_body[42]};
                            pt.last_point     = (k == POINTS_PER_PACKET - 1);
                            expected_points.insert(expected_points.size(), pt);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_pending.insert(rx_pending.size(), b);
        bytes_queued++;
    endtask

    // whole packet, or a cut-off one when body_len is short of the payload
    task automatic queue_packet(input logic [15:0] start_ang, input logic [15:0] end_ang,
                                input bit bad_check, input int body_len);
        logic [7:0] body [PAYLOAD_LEN];
        logic [7:0] crc;
        crc = cfg_seed;
        for (int i = 0; i < PAYLOAD_LEN; i++)
            body[i] = 8'($urandom_range(0, 255));
        body[2]            = start_ang[7:0];
        body[3]            = start_ang[15:8];
        body[TAIL_OFF]     = end_ang[7:0];
        body[TAIL_OFF + 1] = end_ang[15:8];
        push_byte(cfg_header);
        push_byte(cfg_verlen);
        for (int i = 0; i < body_len; i++)
        begin
            push_byte(body[i]);
            crc = crc8_fold(crc, body[i], cfg_poly);
        end
        if (body_len == PAYLOAD_LEN)
            push_byte(bad_check ? crc ^ 8'($urandom_range(1, 255)) : crc);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0:       a = 16'd0;
            1:       a = 16'd35999;
            2:       a = 16'd36000;
            3:       a = 16'hFFFF;
            4, 5, 6: a = 16'($urandom_range(0, 65535));
            default: a = 16'($urandom_range(0, 35999));
        endcase
        return a;
    endfunction

    task automatic fill_random(input int quota);
        int         stop_at;
        int         kind;
        int         n;
        logic [7:0] b;
        stop_at = bytes_queued + quota;
        while (bytes_queued < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 62)
                queue_packet(pick_angle(), pick_angle(), 1'b0, PAYLOAD_LEN);
            else if (kind < 74)
                queue_packet(pick_angle(), pick_angle(), 1'b1, PAYLOAD_LEN);
            else if (kind < 82)
            begin
                push_byte(cfg_header);
                if ($urandom_range(0, 1) == 1 && cfg_header != cfg_verlen)
                    push_byte(cfg_header);
                else
                    push_byte(cfg_verlen ^ 8'($urandom_range(1, 255)));
            end
            else if (kind < 92)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == cfg_header)
                        b = ~b;
                    push_byte(b);
                end
            end
            else
                queue_packet(pick_angle(), pick_angle(), 1'b0,
                             $urandom_range(0, PAYLOAD_LEN - 1));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_pending.size() != 0 || byte_bus.valid || expected_points.size() != 0);
    endtask

    task automatic apb_write(input lpd_reg_t idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POLY:   cfg_poly   = value;
            REG_SEED:   cfg_seed   = value;
            REG_HEADER: cfg_header = value;
            REG_VERLEN: cfg_verlen = value;
            default:    ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] poly, input logic [7:0] seed,
                                input logic [7:0] hdr, input logic [7:0] verlen);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_POLY, poly);
        apb_write(REG_SEED, seed);
        apb_write(REG_HEADER, hdr);
        apb_write(REG_VERLEN, verlen);
    endtask

    initial
    begin
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        #0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        push_byte(8'h00);
        push_byte(8'hFF);
        // repeated header: second copy is dropped, third starts the packet
        push_byte(cfg_header);
        push_byte(cfg_header);
        queue_packet(16'd35000, 16'd1000, 1'b0, PAYLOAD_LEN);
        push_byte(cfg_header);
        push_byte(8'h00);
        queue_packet(16'hFFFF, 16'd0, 1'b0, PAYLOAD_LEN);
        queue_packet(16'd36000, 16'd36000, 1'b1, PAYLOAD_LEN);
        queue_packet(16'd0, 16'd35999, 1'b0, PAYLOAD_LEN);
        fill_random(PHASE_BYTES);

        apply_config(8'hFF, 8'h00, 8'hFF, 8'h00);
        fill_random(PHASE_BYTES);
        apply_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        fill_random(PHASE_BYTES);
        apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        fill_random(PHASE_BYTES);
        apply_config(POLY_RESET, SEED_RESET, HEADER_RESET, VERLEN_RESET);
        fill_random(PHASE_BYTES);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.valid   <= 1'b0;
            byte_bus.rx_byte <= '0;
            send_gap = 0;
        end
        else if (!byte_bus.valid || byte_bus.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                byte_bus.valid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                byte_bus.valid   <= 1'b1;
                byte_bus.rx_byte <= rx_pending.pop_front();
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 10);
            end
            else
                byte_bus.valid <= 1'b0;
        end
    end

    // byte transfer monitor feeding the point predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_state  = HUNT_HEADER;
            payload_fill = 0;
            frame_crc    = cfg_seed;
        end
        else if (byte_bus.valid && byte_bus.ready)
            deframe_byte(byte_bus.rx_byte);
    end

    // point receiver, with two long hold-offs to back up the byte input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_bus.ready <= 1'b0;
            hold_left = 0;
        end
        else if (point_bus.valid && point_bus.ready)
        begin
            points_taken++;
            if (points_taken == 30 || points_taken == 90)
                hold_left = LONG_HOLD;
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                hold_left = recv_burst ? 0 : $urandom_range(0, 10);
            end
            point_bus.ready <= (hold_left == 0);
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            point_bus.ready <= (hold_left == 0);
        end
        else
            point_bus.ready <= 1'b1;
    end

    // point checker
    always @(posedge clk)
    begin : point_check
        scan_point_t want;
        if (rst_n && point_bus.valid && point_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point transfer with none expected, point_index %0d",
                       point_bus.point_index);
                failed = 1'b1;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("distance_mm", 32'(want.distance_mm),
                            32'(point_bus.distance_mm));
                check_field("intensity", 32'(want.intensity), 32'(point_bus.intensity));
                check_field("angle_centideg", 32'(want.angle_centideg),
                            32'(point_bus.angle_centideg));
                check_field("point_index", 32'(want.point_index),
                            32'(point_bus.point_index));
                check_field("rotor_speed", 32'(want.rotor_speed),
                            32'(point_bus.rotor_speed));
                check_field("time_stamp", 32'(want.time_stamp), 32'(point_bus.time_stamp));
                check_field("last_point", 32'(want.last_point), 32'(point_bus.last_point));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
